FILE: sv/postfix_stack_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Postfix stack evaluator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pse_pkg.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Token and status codes, operator bytes, shared types and the clamp helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  // Default sizing.
  localparam int unsigned STACK_DEPTH   = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned DATA_W        = 32;

  // Saturation bounds of a signed data word.
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Operator bytes (ASCII).
  localparam logic [7:0] OP_ADD = 8'h2B;
  localparam logic [7:0] OP_SUB = 8'h2D;
  localparam logic [7:0] OP_MUL = 8'h2A;
  localparam logic [7:0] OP_DIV = 8'h2F;

  // Token kinds.
  typedef enum logic [1:0] {
    MODE_NUM  = 2'd0,
    MODE_OP   = 2'd1,
    MODE_END  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_BADOP     = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_EMPTY_END = 3'd5,
    ST_LEFTOVER  = 3'd6
  } status_e;

  // Clamped value with its saturation flag.
  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] value;
  } clamp_t;

  // Divider result handed back to the controller.
  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DATA_W-1:0] value;
  } div_res_t;

  // Clamp a double-width signed value into one data word.
  function automatic clamp_t clamp64(input logic [2*DATA_W-1:0] v);
    clamp_t r;
    if ((v[2*DATA_W-1:DATA_W-1] == '0) || (v[2*DATA_W-1:DATA_W-1] == '1)) begin
      r.sat   = 1'b0;
      r.value = v[DATA_W-1:0];
    end else begin
      r.sat   = 1'b1;
      r.value = v[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Number, end and erroring items load their result into the output register.
// Add and subtract: stack read, sum or difference, write-back. Multiply: stack
// read, product, clamp, write-back. Divide runs the one-bit-per-cycle divider.
// Reset empties the stack and clears the sticky error at once; the value
// memory is not cleared, since only entries below the pointer are read.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH   = pse_pkg::STACK_DEPTH,
  parameter int unsigned FRACTION_BITS = pse_pkg::FRACTION_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic signed [31:0]                 operand_value_i,
  input  logic [7:0]                         operator_char_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic signed [31:0]                 result_value_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   stack_depth_o,
  output logic                               saturated_o,
  output logic                               expression_done_o
);

  localparam int unsigned W  = pse_pkg::DATA_W;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  // Control and working registers.
  state_e                  state_q, state_d;
  logic [SW-1:0]           sp_q, sp_d;
  pse_pkg::status_e        sticky_q, sticky_d;
  logic [W-1:0]            top_q, top_d;
  alu_op_e                 alu_q, alu_d;
  logic [W-1:0]            res_q, res_d;
  logic                    rsat_q, rsat_d;
  logic signed [2*W-1:0]   prod_q, prod_d;

  // Output register.
  logic                    out_valid_q;
  pse_pkg::status_e        out_status_q;
  logic [W-1:0]            out_value_q;
  logic [SW-1:0]           out_depth_q;
  logic                    out_sat_q;
  logic                    out_done_q;

  // Memory and divider connections.
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [W-1:0]            wr_data;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [W-1:0]            rd_data;
  logic                    div_start;
  pse_pkg::div_res_t       div_res;

  // Combinational helpers.
  logic                    acc;
  logic                    out_free;
  logic [SW-1:0]           sp_m2;
  logic signed [W-1:0]     left_s, right_s;
  logic [2*W-1:0]          sum_w, dif_w;
  pse_pkg::clamp_t         cl_sum, cl_dif, cl_mul;
  logic                    err;
  pse_pkg::status_e        err_code;
  logic                    load;
  pse_pkg::status_e        ld_status;
  logic [W-1:0]            ld_value;
  logic [SW-1:0]           ld_depth;
  logic                    ld_sat;
  logic                    ld_done;

  pse_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pse_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_data),
    .divisor_i  (top_q),
    .res_o      (div_res)
  );

  // Handshake: one item in flight, the output register acts as the skid.
  assign acc        = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;

  // Arithmetic on the left operand from memory and the cached top of stack.
  always_comb begin
    sp_m2   = sp_q - SW'(2);
    left_s  = rd_data;
    right_s = top_q;
    sum_w   = {{W{rd_data[W-1]}}, rd_data} + {{W{top_q[W-1]}}, top_q};
    dif_w   = {{W{rd_data[W-1]}}, rd_data} - {{W{top_q[W-1]}}, top_q};
    cl_sum  = pse_pkg::clamp64(sum_w);
    cl_dif  = pse_pkg::clamp64(dif_w);
    cl_mul  = pse_pkg::clamp64(prod_q >>> FRACTION_BITS);
  end

  // Sequencer: token decode, operand fetch, evaluation and write-back.
  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    sticky_d  = sticky_q;
    top_d     = top_q;
    alu_d     = alu_q;
    res_d     = res_q;
    rsat_d    = rsat_q;
    prod_d    = prod_q;
    wr_en     = 1'b0;
    wr_addr   = sp_q[AW-1:0];
    wr_data   = operand_value_i;
    rd_en     = 1'b0;
    rd_addr   = sp_m2[AW-1:0];
    div_start = 1'b0;
    err       = 1'b0;
    err_code  = pse_pkg::ST_OK;
    load      = 1'b0;
    ld_status = pse_pkg::ST_OK;
    ld_value  = '0;
    ld_depth  = '0;
    ld_sat    = 1'b0;
    ld_done   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (mode_i == pse_pkg::MODE_END) begin
            // End of expression: pop the answer and leave an empty stack.
            load     = 1'b1;
            ld_done  = 1'b1;
            sticky_d = pse_pkg::ST_OK;
            sp_d     = '0;
            if (sticky_q != pse_pkg::ST_OK) begin
              ld_status = sticky_q;
            end else if (sp_q == '0) begin
              ld_status = pse_pkg::ST_EMPTY_END;
            end else begin
              ld_value = top_q;
              if (sp_q != SW'(1)) begin
                ld_status = pse_pkg::ST_LEFTOVER;
              end
            end
          end else if (sticky_q != pse_pkg::ST_OK) begin
            // Items after an error only repeat the error.
            load      = 1'b1;
            ld_status = sticky_q;
          end else if (mode_i == pse_pkg::MODE_NUM) begin
            if (sp_q == SW'(STACK_DEPTH)) begin
              err      = 1'b1;
              err_code = pse_pkg::ST_OVERFLOW;
            end else begin
              wr_en    = 1'b1;
              sp_d     = sp_q + SW'(1);
              top_d    = operand_value_i;
              load     = 1'b1;
              ld_value = operand_value_i;
              ld_depth = sp_q + SW'(1);
            end
          end else if (mode_i == pse_pkg::MODE_RSVD) begin
            err      = 1'b1;
            err_code = pse_pkg::ST_BADOP;
          end else if (sp_q < SW'(2)) begin
            err      = 1'b1;
            err_code = pse_pkg::ST_UNDERFLOW;
          end else begin
            // Valid operator: fetch the left operand from memory.
            case (operator_char_i)
              pse_pkg::OP_ADD: begin
                alu_d   = ALU_ADD;
                rd_en   = 1'b1;
                state_d = S_LOAD;
              end
              pse_pkg::OP_SUB: begin
                alu_d   = ALU_SUB;
                rd_en   = 1'b1;
                state_d = S_LOAD;
              end
              pse_pkg::OP_MUL: begin
                alu_d   = ALU_MUL;
                rd_en   = 1'b1;
                state_d = S_LOAD;
              end
              pse_pkg::OP_DIV: begin
                if (top_q == '0) begin
                  err      = 1'b1;
                  err_code = pse_pkg::ST_DIVZERO;
                end else begin
                  alu_d   = ALU_DIV;
                  rd_en   = 1'b1;
                  state_d = S_LOAD;
                end
              end
              default: begin
                err      = 1'b1;
                err_code = pse_pkg::ST_BADOP;
              end
            endcase
          end

          // Any error empties the stack and becomes sticky.
          if (err) begin
            load      = 1'b1;
            ld_status = err_code;
            sticky_d  = err_code;
            sp_d      = '0;
          end
        end
      end
      S_LOAD: begin
        case (alu_q)
          ALU_ADD: begin
            res_d   = cl_sum.value;
            rsat_d  = cl_sum.sat;
            state_d = S_FIN;
          end
          ALU_SUB: begin
            res_d   = cl_dif.value;
            rsat_d  = cl_dif.sat;
            state_d = S_FIN;
          end
          ALU_MUL: begin
            prod_d  = left_s * right_s;
            state_d = S_MUL;
          end
          ALU_DIV: begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        // Arithmetic shift of the product rounds toward minus infinity.
        res_d   = cl_mul.value;
        rsat_d  = cl_mul.sat;
        state_d = S_FIN;
      end
      S_DIV: begin
        if (div_res.done) begin
          res_d   = div_res.value;
          rsat_d  = div_res.sat;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Result replaces the two operands once the output slot is free.
        if (out_free) begin
          wr_en    = 1'b1;
          wr_addr  = sp_m2[AW-1:0];
          wr_data  = res_q;
          sp_d     = sp_q - SW'(1);
          top_d    = res_q;
          load     = 1'b1;
          ld_value = res_q;
          ld_depth = sp_q - SW'(1);
          ld_sat   = rsat_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      sticky_q    <= pse_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sp_q     <= sp_d;
      sticky_q <= sticky_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    alu_q  <= alu_d;
    res_q  <= res_d;
    rsat_q <= rsat_d;
    prod_q <= prod_d;
    if (load) begin
      out_status_q <= ld_status;
      out_value_q  <= ld_value;
      out_depth_q  <= ld_depth;
      out_sat_q    <= ld_sat;
      out_done_q   <= ld_done;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign result_value_o    = out_value_q;
  assign stack_depth_o     = out_depth_q;
  assign saturated_o       = out_sat_q;
  assign expression_done_o = out_done_q;

endmodule

`default_nettype wire

FILE: sv/pse_stack_ram.sv
// ----------------------------------------------------------------------------
// Postfix stack value memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_stack_ram #(
  parameter int unsigned DEPTH = pse_pkg::STACK_DEPTH,
  parameter int unsigned WIDTH = pse_pkg::DATA_W
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/pse_div.sv
// ----------------------------------------------------------------------------
// Postfix fixed-point divider
// Restoring divider on magnitudes, one quotient bit per cycle, with an
// up-front range check and a final sign and clamp step.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_div #(
  parameter int unsigned FRACTION_BITS = pse_pkg::FRACTION_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pse_pkg::DATA_W-1:0] dividend_i,
  input  logic [pse_pkg::DATA_W-1:0] divisor_i,
  output pse_pkg::div_res_t          res_o
);

  localparam int unsigned W  = pse_pkg::DATA_W;
  localparam int unsigned CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_RUN  = 3'b010,
    DS_FIX  = 3'b100
  } dstate_e;

  dstate_e         state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic            ovf_q, ovf_d;
  logic [W-1:0]    mag_a, mag_b;
  logic [2*W-1:0]  scaled;
  logic [W:0]      trial;
  logic [2*W-1:0]  signed_quo;
  pse_pkg::clamp_t fix;

  // Operand magnitudes, scaled dividend and the per-bit step.
  always_comb begin
    mag_a      = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
    mag_b      = divisor_i[W-1] ? (~divisor_i + 1'b1) : divisor_i;
    scaled     = {{W{1'b0}}, mag_a} << FRACTION_BITS;
    trial      = {rem_q, quo_q[W-1]};
    signed_quo = neg_q ? (~{{W{1'b0}}, quo_q} + 1'b1) : {{W{1'b0}}, quo_q};
    fix        = pse_pkg::clamp64(signed_quo);

    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;

    case (state_q)
      DS_IDLE: begin
        if (start_i) begin
          // A high half not below the divisor means the quotient needs more
          // than one word and saturates without iterating.
          neg_d   = dividend_i[W-1] ^ divisor_i[W-1];
          dvs_d   = mag_b;
          rem_d   = scaled[2*W-1:W];
          quo_d   = scaled[W-1:0];
          cnt_d   = CW'(W);
          ovf_d   = (scaled[2*W-1:W] >= mag_b);
          state_d = (scaled[2*W-1:W] >= mag_b) ? DS_FIX : DS_RUN;
        end
      end
      DS_RUN: begin
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = W'(trial - {1'b0, dvs_q});
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          rem_d = trial[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = DS_FIX;
        end
      end
      DS_FIX: begin
        state_d = DS_IDLE;
      end
      default: begin
        state_d = DS_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    ovf_q <= ovf_d;
  end

  // Result is presented for the single cycle of the fix step.
  always_comb begin
    res_o.done  = (state_q == DS_FIX);
    res_o.sat   = ovf_q | fix.sat;
    res_o.value = ovf_q ? (neg_q ? pse_pkg::SAT_MIN : pse_pkg::SAT_MAX) : fix.value;
  end

endmodule

`default_nettype wire

FILE: sv/pse_checker.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator port checker
// Checks result consistency and output hold behavior seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_stack_evaluator_defines.svh"

module pse_checker #(
  parameter int unsigned STACK_DEPTH = pse_pkg::STACK_DEPTH
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic [2:0]                       status_o,
  input wire logic [31:0]                      result_value_o,
  input wire logic [$clog2(STACK_DEPTH+1)-1:0] stack_depth_o,
  input wire logic                             saturated_o,
  input wire logic                             expression_done_o
);

  // An end item always leaves the stack empty.
  `PSE_ASSERT_IMP(a_done_empty, clk_i, rst_ni,
    out_valid_o && expression_done_o, stack_depth_o == '0,
    "end item left values on the stack")

  // An error result outside an end item reports an empty stack and zero.
  `PSE_ASSERT_IMP(a_err_cleared, clk_i, rst_ni,
    out_valid_o && !expression_done_o && (status_o != pse_pkg::ST_OK),
    (stack_depth_o == '0) && (result_value_o == '0),
    "error result without cleared stack")

  // Saturation only comes with a successful arithmetic result.
  `PSE_ASSERT_IMP(a_sat_ok, clk_i, rst_ni,
    out_valid_o && saturated_o,
    (status_o == pse_pkg::ST_OK) && !expression_done_o,
    "saturation flagged on a non-arithmetic result")

  // End-only status codes appear only on end items.
  `PSE_ASSERT_IMP(a_end_codes, clk_i, rst_ni,
    out_valid_o && ((status_o == pse_pkg::ST_EMPTY_END) ||
                    (status_o == pse_pkg::ST_LEFTOVER)),
    expression_done_o, "end status on a non-end item")

  // A stalled result holds.
  `PSE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(result_value_o) &&
    $stable(stack_depth_o), "stalled result changed")

endmodule

bind postfix_stack_evaluator pse_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_pse_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .result_value_o    (result_value_o),
  .stack_depth_o     (stack_depth_o),
  .saturated_o       (saturated_o),
  .expression_done_o (expression_done_o)
);

`default_nettype wire

FILE: bench/postfix_result_checker.sv
// ----------------------------------------------------------------------------
// Postfix evaluator result checker
// Watches both channels of the evaluator. For each accepted token it
// evaluates the expected result on its own copy of the value stack, then
// matches every accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module postfix_result_checker
  import pse_pkg::*;
(
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [1:0]                         mode_i,
  input  logic [31:0]                        operand_value_i,
  input  logic [7:0]                         operator_char_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [2:0]                         status_i,
  input  logic [31:0]                        result_value_i,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]   stack_depth_i,
  input  logic                               saturated_i,
  input  logic                               expression_done_i,
  output int unsigned                        mismatch_count_o,
  output int unsigned                        outstanding_o
);

  typedef struct packed {
    status_e                            status;
    logic [DATA_W-1:0]                  value;
    logic [$clog2(STACK_DEPTH+1)-1:0]   depth;
    logic                               sat;
    logic                               done;
  } answer_t;

  // Shadow evaluator state.
  logic [DATA_W-1:0] value_mem [STACK_DEPTH];
  int unsigned       held_count;
  status_e           sticky_code;

  // Predicted answers, oldest first.
  answer_t answer_q [$];

  // Evaluate one token against the shadow stack and return the result it gives.
  function automatic answer_t evaluate_token(input mode_e kind, input logic [31:0] number,
                                             input logic [7:0] op);
    answer_t     ans;
    longint      lhs;
    longint      rhs;
    longint      full;
    ans = '0;
    ans.status = ST_OK;
    full = 0;
    if (kind == MODE_END) begin
      // An end token pops the answer and always leaves the stack empty.
      ans.done = 1'b1;
      if (sticky_code != ST_OK) begin
        ans.status = sticky_code;
      end else if (held_count == 0) begin
        ans.status = ST_EMPTY_END;
      end else begin
        held_count--;
        ans.value = value_mem[held_count];
        if (held_count != 0) ans.status = ST_LEFTOVER;
      end
      sticky_code = ST_OK;
      held_count = 0;
    end else if (sticky_code != ST_OK) begin
      ans.status = sticky_code;
    end else if (kind == MODE_NUM) begin
      if (held_count >= STACK_DEPTH) begin
        ans.status = ST_OVERFLOW;
      end else begin
        value_mem[held_count] = number;
        held_count++;
      end
    end else if (kind == MODE_RSVD) begin
      ans.status = ST_BADOP;
    end else if (held_count < 2) begin
      ans.status = ST_UNDERFLOW;
    end else begin
      // Operands are consumed even when the operator turns out to be bad.
      rhs = longint'($signed(value_mem[held_count-1]));
      lhs = longint'($signed(value_mem[held_count-2]));
      held_count -= 2;
      case (op)
        OP_ADD: full = lhs + rhs;
        OP_SUB: full = lhs - rhs;
        OP_MUL: full = (lhs * rhs) >>> FRACTION_BITS;
        OP_DIV: begin
          if (rhs == 0) ans.status = ST_DIVZERO;
          else full = (lhs <<< FRACTION_BITS) / rhs;
        end
        default: ans.status = ST_BADOP;
      endcase
      if (ans.status == ST_OK) begin
        if (full > 64'sd2147483647) begin
          full = 64'sd2147483647;
          ans.sat = 1'b1;
        end else if (full < -64'sd2147483648) begin
          full = -64'sd2147483648;
          ans.sat = 1'b1;
        end
        value_mem[held_count] = full[31:0];
        held_count++;
      end
    end
    // Any error outside an end token empties the stack and sticks.
    if (ans.status != ST_OK && !ans.done) begin
      sticky_code = ans.status;
      held_count = 0;
    end
    if (!ans.done) ans.value = (held_count == 0) ? '0 : value_mem[held_count-1];
    ans.depth = held_count[$clog2(STACK_DEPTH+1)-1:0];
    return ans;
  endfunction

  // Compare one result field and count a mismatch.
  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count_o++;
    end
  endtask

  // Results are checked before the token of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      held_count = 0;
      sticky_code = ST_OK;
      answer_q.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $error("result accepted with no item outstanding");
          mismatch_count_o++;
        end else begin
          want = answer_q.pop_front();
          compare_field("status", 32'(want.status), 32'(status_i));
          compare_field("result_value", want.value, result_value_i);
          compare_field("stack_depth", 32'(want.depth), 32'(stack_depth_i));
          compare_field("saturated", 32'(want.sat), 32'(saturated_i));
          compare_field("expression_done", 32'(want.done), 32'(expression_done_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        answer_q.push_back(evaluate_token(mode_e'(mode_i), operand_value_i, operator_char_i));
      end
      outstanding_o = answer_q.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Postfix stack evaluator testbench
// Drives a short directed token sequence through the evaluator, then random
// postfix expressions, mostly well formed and some broken, under three
// sender/receiver idling mixes. A checker beside the block predicts and
// compares every result; the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import pse_pkg::*;

  localparam int unsigned TOKEN_TARGET = 1350;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 60;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       mode;
  logic signed [31:0]               operand_value;
  logic [7:0]                       operator_char;
  logic                             out_valid;
  logic                             out_stall;
  logic [2:0]                       status;
  logic signed [31:0]               result_value;
  logic [$clog2(STACK_DEPTH+1)-1:0] stack_depth;
  logic                             saturated;
  logic                             expression_done;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count;
  int unsigned token_count;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  postfix_stack_evaluator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .mode_i            (mode),
    .operand_value_i   (operand_value),
    .operator_char_i   (operator_char),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .result_value_o    (result_value),
    .stack_depth_o     (stack_depth),
    .saturated_o       (saturated),
    .expression_done_o (expression_done)
  );

  postfix_result_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .mode_i            (mode),
    .operand_value_i   (operand_value),
    .operator_char_i   (operator_char),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .status_i          (status),
    .result_value_i    (result_value),
    .stack_depth_i     (stack_depth),
    .saturated_i       (saturated),
    .expression_done_i (expression_done),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  // Clock with a period of 10.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Cycle counter and run limit.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // The receiver stalls at random each cycle.
  always @(negedge clk_i) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // Random operand: zero, extremes, full range or small Q16.16 values.
  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: begin
        case ($urandom_range(0, 3))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_operator();
    logic [7:0] c;
    do c = $urandom_range(0, 255);
    while (c inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV});
    return c;
  endfunction

  // Present one token at a falling edge and hold it until it is accepted.
  task automatic send_token(input mode_e kind, input logic [31:0] number,
                            input logic [7:0] op);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid      <= 1'b0;
      mode          <= $urandom_range(0, 3);
      operand_value <= $urandom;
      operator_char <= $urandom_range(0, 255);
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    mode          <= kind;
    operand_value <= number;
    operator_char <= op;
    do @(posedge clk_i); while (in_stall);
    token_count++;
  endtask

  // One random expression: mostly well formed, sometimes broken.
  task automatic run_expression();
    int unsigned flavor;
    int unsigned target;
    int unsigned pushed;
    int unsigned held;
    flavor = $urandom_range(0, 99);
    if (flavor < 5) begin
      // Fill the stack to just below, at, or past its capacity.
      repeat (STACK_DEPTH - 1 + $urandom_range(0, 2))
        send_token(MODE_NUM, pick_number(), $urandom_range(0, 255));
    end else if (flavor >= 8) begin
      target = $urandom_range(1, 8);
      pushed = 0;
      held = 0;
      while (pushed < target || held > 1) begin
        if (pushed < target && (held < 2 || $urandom_range(0, 1))) begin
          send_token(MODE_NUM, pick_number(), $urandom_range(0, 255));
          pushed++;
          held++;
        end else begin
          send_token(MODE_OP, $urandom, pick_operator());
          held--;
        end
      end
      // Break the tail of some expressions.
      if (flavor < 14) begin
        send_token(MODE_OP, $urandom, pick_operator());
      end else if (flavor < 19) begin
        send_token(MODE_NUM, pick_number(), $urandom_range(0, 255));
        send_token(MODE_OP, $urandom, pick_bad_operator());
      end else if (flavor < 22) begin
        send_token(MODE_RSVD, $urandom, $urandom_range(0, 255));
      end else if (flavor < 27) begin
        send_token(MODE_NUM, pick_number(), $urandom_range(0, 255));
      end
      // Tokens after an error must be ignored until the end token.
      if (flavor < 22) begin
        repeat ($urandom_range(0, 2))
          send_token(mode_e'($urandom_range(0, 1)), pick_number(), pick_operator());
      end
    end
    send_token(MODE_END, $urandom, $urandom_range(0, 255));
  endtask

  // Stimulus and verdict.
  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    mode           = MODE_NUM;
    operand_value  = '0;
    operator_char  = '0;
    out_stall      = 1'b0;
    cycle_count    = 0;
    token_count    = 0;
    send_gap_pct   = 13;
    recv_stall_pct = 77;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // End on an empty stack.
    send_token(MODE_END, $urandom, $urandom_range(0, 255));
    // Saturating add, subtract, multiply and divide, then a floored product.
    send_token(MODE_NUM, SAT_MAX, OP_ADD);
    send_token(MODE_NUM, SAT_MAX, OP_ADD);
    send_token(MODE_OP, '0, OP_ADD);
    send_token(MODE_NUM, SAT_MIN, OP_ADD);
    send_token(MODE_NUM, 32'h0000_0001, OP_ADD);
    send_token(MODE_OP, '0, OP_SUB);
    send_token(MODE_OP, '0, OP_MUL);
    send_token(MODE_NUM, 32'hFFFF_FFFF, OP_ADD);
    send_token(MODE_OP, '0, OP_DIV);
    send_token(MODE_NUM, 32'hFFFF_FFFF, OP_ADD);
    send_token(MODE_OP, '0, OP_MUL);
    // Leftover value at the end.
    send_token(MODE_NUM, 32'h0003_0000, OP_ADD);
    send_token(MODE_END, '1, 8'hFF);
    // Divide by zero, then a number ignored under the sticky error.
    send_token(MODE_NUM, 32'h0001_0000, OP_ADD);
    send_token(MODE_NUM, 32'h0, OP_ADD);
    send_token(MODE_OP, '0, OP_DIV);
    send_token(MODE_NUM, 32'h0005_0000, OP_ADD);
    send_token(MODE_END, '0, 8'h00);
    // Too few operands, checked before the operator byte.
    send_token(MODE_NUM, 32'h0001_0000, OP_ADD);
    send_token(MODE_OP, '0, 8'h78);
    send_token(MODE_END, '0, 8'h00);
    // Unknown operator byte, then the reserved token kind.
    send_token(MODE_NUM, 32'h0001_0000, OP_ADD);
    send_token(MODE_NUM, 32'h0002_0000, OP_ADD);
    send_token(MODE_OP, '0, 8'h78);
    send_token(MODE_RSVD, '0, OP_ADD);
    send_token(MODE_END, '0, 8'h00);

    // Random expressions under three idling mixes.
    while (token_count < TOKEN_TARGET) begin
      if (token_count < TOKEN_TARGET / 3) begin
        send_gap_pct   = 13;
        recv_stall_pct = 77;
      end else if (token_count < 2 * TOKEN_TARGET / 3) begin
        send_gap_pct   = 77;
        recv_stall_pct = 13;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      run_expression();
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/pse_pkg.sv
sv/pse_stack_ram.sv
sv/pse_div.sv
sv/postfix_stack_evaluator.sv
sv/pse_checker.sv
bench/postfix_result_checker.sv
bench/testbench.sv
